@@ rtl/sat_pkg.sv @@
`timescale 1ns / 1ps
package sat_pkg;

  // Fixed field widths of the stream and the configuration port
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned ROWSUM_W = 18;
  localparam int unsigned SUM_W    = 28;
  localparam int unsigned CFG_DW   = 11;
  localparam int unsigned CFG_IW   = 2;

  // Reset values of the configuration registers (before clamping)
  localparam int unsigned CFG_WIDTH_RST    = 1024;
  localparam int unsigned CFG_HEIGHT_RST   = 1024;
  localparam int unsigned CFG_CHANNELS_RST = 1;

  typedef enum logic [CFG_IW-1:0] {
    REG_WIDTH    = 2'd0,
    REG_HEIGHT   = 2'd1,
    REG_CHANNELS = 2'd2
  } cfg_reg_e;

  // Classification of one sample, set by the front end
  typedef struct packed {
    logic first_row;   // line store reads as zero
    logic row_end;     // last channel of last column: clear row sums after
    logic frame_last;  // last sample of the frame
  } item_flags_t;

  localparam int unsigned FLAGS_W = $bits(item_flags_t);

endpackage

@@ rtl/sat_ram.sv @@
`timescale 1ns / 1ps
module sat_ram #(
  parameter int unsigned WIDTH = 28,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/sat_front.sv @@
`timescale 1ns / 1ps
module sat_front
  import sat_pkg::*;
#(
  parameter int unsigned MAX_WIDTH    = 1024,
  parameter int unsigned MAX_HEIGHT   = 1024,
  parameter int unsigned MAX_CHANNELS = 4,
  parameter int unsigned COLW         = 10,
  parameter int unsigned ROWW         = 10,
  parameter int unsigned CHW          = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_IW-1:0]   cfg_index_i,
  input  logic [CFG_DW-1:0]   cfg_data_i,
  input  logic                in_valid_i,
  input  logic                full_i,
  output logic                push_o,
  output logic                restart_o,
  output logic [COLW+CHW-1:0] slot_o,
  output item_flags_t         flags_o
);

  localparam int unsigned CLW = 13;
  localparam logic [CLW-1:0] MaxW = CLW'(MAX_WIDTH);
  localparam logic [CLW-1:0] MaxH = CLW'(MAX_HEIGHT);
  localparam logic [CLW-1:0] MaxC = CLW'(MAX_CHANNELS);
  localparam int unsigned RstW = (CFG_WIDTH_RST < MAX_WIDTH) ? CFG_WIDTH_RST : MAX_WIDTH;
  localparam int unsigned RstH = (CFG_HEIGHT_RST < MAX_HEIGHT) ? CFG_HEIGHT_RST : MAX_HEIGHT;
  localparam int unsigned RstC =
    (CFG_CHANNELS_RST < MAX_CHANNELS) ? CFG_CHANNELS_RST : MAX_CHANNELS;

  logic [COLW-1:0] col_last_q, col_last_d;
  logic [ROWW-1:0] row_last_q, row_last_d;
  logic [CHW-1:0]  ch_last_q, ch_last_d;
  logic [COLW-1:0] col_q, col_d;
  logic [ROWW-1:0] row_q, row_d;
  logic [CHW-1:0]  ch_q, ch_d;
  logic [CLW-1:0]  cfg_ext, clamp_w, clamp_h, clamp_c;
  logic            restart, last_ch, last_col, last_row;

  // Saturate the written value into 1..max, keep the last index
  assign cfg_ext = CLW'(cfg_data_i);
  always_comb begin
    clamp_w = (cfg_ext == '0) ? CLW'(1) : ((cfg_ext > MaxW) ? MaxW : cfg_ext);
    clamp_h = (cfg_ext == '0) ? CLW'(1) : ((cfg_ext > MaxH) ? MaxH : cfg_ext);
    clamp_c = (cfg_ext[2:0] == '0) ? CLW'(1) :
              ((CLW'(cfg_data_i[2:0]) > MaxC) ? MaxC : CLW'(cfg_data_i[2:0]));
  end

  always_comb begin
    col_last_d = col_last_q;
    row_last_d = row_last_q;
    ch_last_d  = ch_last_q;
    restart    = 1'b0;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_WIDTH: begin
          col_last_d = COLW'(clamp_w - CLW'(1));
          restart    = 1'b1;
        end
        REG_HEIGHT: begin
          row_last_d = ROWW'(clamp_h - CLW'(1));
          restart    = 1'b1;
        end
        REG_CHANNELS: begin
          ch_last_d = CHW'(clamp_c - CLW'(1));
          restart   = 1'b1;
        end
        default: restart = 1'b0;
      endcase
    end
  end

  assign push_o    = in_valid_i && !full_i;
  assign restart_o = restart;

  assign last_ch  = (ch_q == ch_last_q);
  assign last_col = (col_q == col_last_q);
  assign last_row = (row_q == row_last_q);

  always_comb begin
    ch_d  = ch_q;
    col_d = col_q;
    row_d = row_q;
    if (restart) begin
      ch_d  = '0;
      col_d = '0;
      row_d = '0;
    end else if (push_o) begin
      if (!last_ch) begin
        ch_d = ch_q + CHW'(1);
      end else begin
        ch_d = '0;
        if (!last_col) begin
          col_d = col_q + COLW'(1);
        end else begin
          col_d = '0;
          row_d = last_row ? '0 : row_q + ROWW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_last_q <= COLW'(RstW - 1);
      row_last_q <= ROWW'(RstH - 1);
      ch_last_q  <= CHW'(RstC - 1);
      col_q      <= '0;
      row_q      <= '0;
      ch_q       <= '0;
    end else begin
      col_last_q <= col_last_d;
      row_last_q <= row_last_d;
      ch_last_q  <= ch_last_d;
      col_q      <= col_d;
      row_q      <= row_d;
      ch_q       <= ch_d;
    end
  end

  assign slot_o             = {col_q, ch_q};
  assign flags_o.first_row  = (row_q == '0);
  assign flags_o.row_end    = last_ch && last_col;
  assign flags_o.frame_last = last_ch && last_col && last_row;

endmodule

@@ rtl/sat_queue.sv @@
`timescale 1ns / 1ps
module sat_queue #(
  parameter int unsigned WIDTH = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic             full_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] entry_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q, count_d;
  logic             do_pop;

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

endmodule

@@ rtl/sat_back.sv @@
`timescale 1ns / 1ps
module sat_back
  import sat_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 4,
  parameter int unsigned COLW         = 10,
  parameter int unsigned CHW          = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                restart_i,
  input  logic                q_valid_i,
  input  logic [COLW+CHW-1:0] q_slot_i,
  input  logic [SAMPLE_W-1:0] q_sample_i,
  input  item_flags_t         q_flags_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SUM_W-1:0]    area_sum_o,
  output logic                frame_last_o
);

  localparam int unsigned SW = COLW + CHW;

  logic                s1_valid_q;
  logic [SW-1:0]       s1_slot_q;
  logic [SAMPLE_W-1:0] s1_sample_q;
  item_flags_t         s1_flags_q;
  logic                fwd_q;
  logic [SUM_W-1:0]    fwd_data_q;
  logic [ROWSUM_W-1:0] rs_q [MAX_CHANNELS];
  logic                out_valid_q;
  logic [SUM_W-1:0]    out_sum_q;
  logic                out_last_q;

  logic                adv, wr_en;
  logic [CHW-1:0]      s1_ch;
  logic [SUM_W-1:0]    rd_data, above, total;
  logic [ROWSUM_W-1:0] rs_new;

  // Whole back end moves together; the output register frees on take
  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = adv && q_valid_i;
  assign wr_en = adv && s1_valid_q;
  assign s1_ch = s1_slot_q[CHW-1:0];

  sat_ram #(
    .WIDTH (SUM_W),
    .DEPTH (1 << SW)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_slot_q),
    .wdata_i (total),
    .re_i    (pop_o),
    .raddr_i (q_slot_i),
    .rdata_o (rd_data)
  );

  // A slot read while the same slot is written takes the written value
  always_comb begin
    rs_new = rs_q[s1_ch] + ROWSUM_W'(s1_sample_q);
    if (s1_flags_q.first_row) begin
      above = '0;
    end else if (fwd_q) begin
      above = fwd_data_q;
    end else begin
      above = rd_data;
    end
    total = above + SUM_W'(rs_new);
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_slot_q   <= q_slot_i;
      s1_sample_q <= q_sample_i;
      s1_flags_q  <= q_flags_i;
    end
    if (adv) begin
      fwd_data_q <= total;
    end
    if (wr_en) begin
      out_sum_q  <= total;
      out_last_q <= s1_flags_q.frame_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        rs_q[i] <= '0;
      end
    end else begin
      if (adv) begin
        s1_valid_q  <= q_valid_i;
        fwd_q       <= pop_o && s1_valid_q && (q_slot_i == s1_slot_q);
        out_valid_q <= s1_valid_q;
      end
      if (restart_i || (wr_en && s1_flags_q.row_end)) begin
        for (int i = 0; i < MAX_CHANNELS; i++) begin
          rs_q[i] <= '0;
        end
      end else if (wr_en) begin
        rs_q[s1_ch] <= rs_new;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign area_sum_o   = out_sum_q;
  assign frame_last_o = out_last_q;

endmodule

@@ rtl/summed_area_table.sv @@
`timescale 1ns / 1ps
// Channel  | Direction | Handshake                       | Beat payload
// ---------+-----------+---------------------------------+---------------------------------
// input    | in        | in_valid_i / in_stall_o         | sample_i
// output   | out       | out_valid_o / out_stall_i       | area_sum_o, frame_last_o
// config   | in        | cfg_we_i (no wait, no readback) | cfg_index_i, cfg_data_i
//
// One sample per clock, sustained while the output is not stalled. An accepted
// input beat passes the queue entry, then the line store read stage, whose add
// lands in the output register that drives out_valid_o.
// The line store (one port for write, one for registered read) sets the pace:
// each sample reads and writes its slot once.
// Reset clears counters, row sums and valid flags; the line store is not
// cleared, since the first row of each frame writes every slot it later reads.
// A stall on the output freezes the back end; the two-entry queue absorbs the
// in-flight beat so the input stalls only once the queue fills.
module summed_area_table
  import sat_pkg::*;
#(
  parameter int unsigned MAX_WIDTH    = 1024,
  parameter int unsigned MAX_HEIGHT   = 1024,
  parameter int unsigned MAX_CHANNELS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_IW-1:0]   cfg_index_i,
  input  logic [CFG_DW-1:0]   cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SUM_W-1:0]    area_sum_o,
  output logic                frame_last_o
);

  // Column, row and channel index widths; the line store slot is {column, channel}
  localparam int unsigned COLW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned ROWW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned CHW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned SW   = COLW + CHW;
  localparam int unsigned QW   = FLAGS_W + SAMPLE_W + SW;

  logic          push, restart, q_full, q_valid, pop;
  logic [SW-1:0] f_slot, q_slot;
  item_flags_t   f_flags, q_flags;
  logic [SAMPLE_W-1:0] q_sample;
  logic [QW-1:0] q_in, q_out;

  // Front end: track position, classify each sample, drop it into the queue
  sat_front #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_CHANNELS (MAX_CHANNELS),
    .COLW         (COLW),
    .ROWW         (ROWW),
    .CHW          (CHW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .full_i      (q_full),
    .push_o      (push),
    .restart_o   (restart),
    .slot_o      (f_slot),
    .flags_o     (f_flags)
  );

  assign in_stall_o = q_full;
  assign q_in       = {f_flags, sample_i, f_slot};

  sat_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_in),
    .pop_i   (pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .data_o  (q_out)
  );

  assign {q_flags, q_sample, q_slot} = q_out;

  // Back end: read the row above, add the running row sum, write back, emit
  sat_back #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .COLW         (COLW),
    .CHW          (CHW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .restart_i    (restart),
    .q_valid_i    (q_valid),
    .q_slot_i     (q_slot),
    .q_sample_i   (q_sample),
    .q_flags_i    (q_flags),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .area_sum_o   (area_sum_o),
    .frame_last_o (frame_last_o)
  );

endmodule

@@ tb/sat_checker.sv @@
`timescale 1ns / 1ps
module sat_checker
  import sat_pkg::*;
#(
  parameter int unsigned MAX_WIDTH    = 1024,
  parameter int unsigned MAX_HEIGHT   = 1024,
  parameter int unsigned MAX_CHANNELS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_IW-1:0]   cfg_index_i,
  input  logic [CFG_DW-1:0]   cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [SUM_W-1:0]    area_sum_i,
  input  logic                frame_last_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  typedef struct packed {
    logic [SUM_W-1:0] area_sum;
    logic             frame_last;
  } sat_beat_t;

  logic [CFG_DW-1:0]   width_reg;
  logic [CFG_DW-1:0]   height_reg;
  logic [CFG_DW-1:0]   chans_reg;
  int unsigned         col_pos;
  int unsigned         row_pos;
  int unsigned         chan_pos;
  logic [ROWSUM_W-1:0] row_acc [MAX_CHANNELS];
  logic [SUM_W-1:0]    line_sums [MAX_WIDTH*MAX_CHANNELS];
  sat_beat_t           pending_sums [$];
  int unsigned         mismatches;

  function automatic int unsigned clamp_dim(logic [CFG_DW-1:0] raw, int unsigned hi);
    if (raw == '0) return 1;
    if (raw > hi) return hi;
    return 32'(raw);
  endfunction

  function automatic void restart_frame();
    col_pos  = 0;
    row_pos  = 0;
    chan_pos = 0;
    foreach (row_acc[i]) row_acc[i] = '0;
  endfunction

  // Table value of one sample, then advance the raster position.
  function automatic sat_beat_t integrate_sample(logic [SAMPLE_W-1:0] s);
    int unsigned      w;
    int unsigned      h;
    int unsigned      c;
    int unsigned      slot;
    logic [SUM_W-1:0] above;
    sat_beat_t        beat;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    c = clamp_dim(chans_reg, MAX_CHANNELS);
    if (chan_pos >= c) chan_pos = 0;
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    slot = col_pos * MAX_CHANNELS + chan_pos;
    row_acc[chan_pos] = row_acc[chan_pos] + ROWSUM_W'(s);
    above = (row_pos == 0) ? '0 : line_sums[slot];
    beat.area_sum = above + SUM_W'(row_acc[chan_pos]);
    line_sums[slot] = beat.area_sum;
    beat.frame_last = (chan_pos + 1 >= c) && (col_pos + 1 >= w) && (row_pos + 1 >= h);
    if (chan_pos + 1 < c) begin
      chan_pos++;
    end else begin
      chan_pos = 0;
      if (col_pos + 1 < w) begin
        col_pos++;
      end else begin
        col_pos = 0;
        foreach (row_acc[i]) row_acc[i] = '0;
        row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end
    end
    return beat;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sat_beat_t want;
    if (!rst_ni) begin
      width_reg  = CFG_DW'(CFG_WIDTH_RST);
      height_reg = CFG_DW'(CFG_HEIGHT_RST);
      chans_reg  = CFG_DW'(CFG_CHANNELS_RST);
      restart_frame();
      pending_sums.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Check the outgoing beat first: it can never be the one accepted now.
      if (out_valid_i && !out_stall_i) begin
        if (pending_sums.size() == 0) begin
          mismatches++;
          $error("unexpected beat: area_sum %0d frame_last %0b", area_sum_i, frame_last_i);
        end else begin
          want = pending_sums.pop_front();
          if (area_sum_i !== want.area_sum) begin
            mismatches++;
            $error("area_sum: expected %0d, got %0d", want.area_sum, area_sum_i);
          end
          if (frame_last_i !== want.frame_last) begin
            mismatches++;
            $error("frame_last: expected %0b, got %0b", want.frame_last, frame_last_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) pending_sums.push_back(integrate_sample(sample_i));
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_WIDTH: begin
            width_reg = cfg_data_i;
            restart_frame();
          end
          REG_HEIGHT: begin
            height_reg = cfg_data_i;
            restart_frame();
          end
          REG_CHANNELS: begin
            // The channel register holds three bits only
            chans_reg = CFG_DW'(cfg_data_i[2:0]);
            restart_frame();
          end
          default: ;
        endcase
      end
      fail_count_o <= mismatches;
      pending_o    <= pending_sums.size();
    end
  end

endmodule

@@ tb/tb_summed_area_table.sv @@
`timescale 1ns / 1ps
module tb_summed_area_table;
  import sat_pkg::*;

  // Index 3 decodes to no register: a write there must not restart the frame.
  localparam logic [CFG_IW-1:0] REG_SPARE = 2'd3;
  // Receiver hold-off, long enough to fill the block and back up the input.
  localparam int unsigned HOLD_CYCLES = 60;
  // 2x2 image, two channels, one full frame plus the start of the next.
  localparam logic [SAMPLE_W-1:0] GRID_SAMPLES [10] = '{
    8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h01, 8'h80
  };

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CFG_IW-1:0]   cfg_index_i;
  logic [CFG_DW-1:0]   cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [SAMPLE_W-1:0] sample_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [SUM_W-1:0]    area_sum_o;
  logic                frame_last_o;

  int unsigned fail_count;
  int unsigned pending;
  bit          idle_on;
  bit          hold_req;

  summed_area_table uut (.*);

  sat_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .sample_i     (sample_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .area_sum_i   (area_sum_o),
    .frame_last_i (frame_last_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or drops beats.
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int unsigned burst;
    out_stall_i = 1'b0;
    burst = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (burst != 0) begin
        burst--;
        if (burst == 0) out_stall_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 6);
        out_stall_i <= 1'b1;
      end
    end
  end

  // Offer one beat, maybe after an idle gap, and hold it until accepted.
  task automatic push_sample(input logic [SAMPLE_W-1:0] value);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Stream random samples; bias toward full scale to push the sums up.
  task automatic push_run(input int unsigned count, input bit full_scale);
    logic [SAMPLE_W-1:0] value;
    repeat (count) begin
      if (full_scale && $urandom_range(0, 3) != 0) value = '1;
      else value = SAMPLE_W'($urandom_range(0, 255));
      push_sample(value);
    end
    in_valid_i <= 1'b0;
  endtask

  // Wait until every beat sent so far has come back.
  task automatic drain();
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Write all three registers back to back; each write restarts the frame.
  task automatic apply_config(input logic [CFG_DW-1:0] w, h, c);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_WIDTH;
    cfg_data_i  <= w;
    @(posedge clk_i);
    cfg_index_i <= REG_HEIGHT;
    cfg_data_i  <= h;
    @(posedge clk_i);
    cfg_index_i <= REG_CHANNELS;
    cfg_data_i  <= c;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic touch_spare();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_SPARE;
    cfg_data_i  <= CFG_DW'($urandom_range(0, 2047));
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    logic [CFG_DW-1:0] w_raw;
    logic [CFG_DW-1:0] h_raw;
    logic [CFG_DW-1:0] c_raw;
    int unsigned       w_eff;
    int unsigned       h_eff;
    int unsigned       c_eff;
    int unsigned       frame_len;
    int unsigned       count;
    int unsigned       phase;
    int unsigned       random_sent;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = REG_WIDTH;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    sample_i    = '0;
    idle_on     = 1'b0;
    hold_req    = 1'b0;
    w_eff       = 1;
    h_eff       = 1;
    c_eff       = 1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: wide single-channel image, first row only.
    push_sample(8'hFF);
    push_sample(8'h00);
    push_sample(8'hFF);
    in_valid_i <= 1'b0;
    drain();

    // Small full frame: end of row, line store read, end of frame, wrap.
    apply_config(CFG_DW'(2), CFG_DW'(2), CFG_DW'(2));
    foreach (GRID_SAMPLES[i]) push_sample(GRID_SAMPLES[i]);
    in_valid_i <= 1'b0;
    drain();

    // All-zero registers act as 1x1x1: every beat closes a frame.
    apply_config(CFG_DW'(0), CFG_DW'(0), CFG_DW'(0));
    push_sample(8'h55);
    push_sample(8'hAA);
    push_sample(8'hFF);
    in_valid_i <= 1'b0;
    drain();

    // Channel count above the maximum saturates to four; a write to the
    // spare index between the rows must leave the frame running.
    apply_config(CFG_DW'(1), CFG_DW'(2), CFG_DW'(7));
    repeat (4) push_sample(8'hFF);
    in_valid_i <= 1'b0;
    drain();
    touch_spare();
    repeat (4) push_sample(8'hFF);
    in_valid_i <= 1'b0;
    drain();

    // Oversized width saturates to the full line; cross into the second row
    // so the line store is read back, with sums near the row limit.
    idle_on = 1'b1;
    apply_config(CFG_DW'(2047), CFG_DW'(2047), CFG_DW'(1));
    push_run(1100, 1'b1);
    drain();

    // Random small frames with saturated and zero settings mixed in.
    random_sent = 0;
    phase = 0;
    while (random_sent < 400) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if (phase != 0 && $urandom_range(0, 5) == 0) begin
        touch_spare();
      end else begin
        w_eff = $urandom_range(1, 6);
        w_raw = (w_eff == 1 && $urandom_range(0, 1) == 1) ? '0 : CFG_DW'(w_eff);
        h_raw = ($urandom_range(0, 9) == 0) ? CFG_DW'(2047) : CFG_DW'($urandom_range(0, 4));
        h_eff = (h_raw == 0) ? 1 : ((h_raw > 4) ? 4 : h_raw);
        c_raw = CFG_DW'($urandom_range(0, 7));
        c_eff = (c_raw == 0) ? 1 : ((c_raw > 4) ? 4 : c_raw);
        apply_config(w_raw, h_raw, c_raw);
      end
      frame_len = w_eff * h_eff * c_eff;
      count = frame_len + $urandom_range(0, frame_len);
      if (phase == 2) begin
        // Long receiver hold while beats keep coming: the input must stall.
        if (count < 80) count = 80;
        hold_req = 1'b1;
      end
      if (phase == 4) begin
        // Pause mid-frame until the block is empty, then carry on.
        push_run(count / 2 + 1, 1'b0);
        drain();
        push_run(count / 2, 1'b0);
      end else begin
        push_run(count, $urandom_range(0, 3) == 0);
      end
      drain();
      random_sent += count;
      phase++;
    end

    // Last stretch at full rate on both sides.
    idle_on = 1'b0;
    apply_config(CFG_DW'(5), CFG_DW'(3), CFG_DW'(3));
    push_run(90, 1'b0);
    drain();
    repeat (20) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
